[src/pmm_pkg.sv]
package pmm_pkg;

	localparam int PMM_PAGE_BYTES = 256;
	localparam int PMM_PAGE_TOTAL = 64;
	localparam int PMM_OFS_W = $clog2(PMM_PAGE_BYTES);
	localparam int PMM_PTR_BASE = 64;

	localparam logic [7:0] MAP_FREE = 8'd0;
	localparam logic [7:0] MAP_USED = 8'd1;

	localparam logic [1:0] OP_NEW = 2'd0;
	localparam logic [1:0] OP_KILL = 2'd1;
	localparam logic [1:0] OP_STORE = 2'd2;
	localparam logic [1:0] OP_LOAD = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NO_TABLE = 2'd1;
	localparam logic [1:0] ST_NO_DATA = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [1:0] status;
		logic [15:0] physical_address;
		logic [7:0] load_data;
	} res_t;

endpackage

[src/paged_memory_manager_top.sv]
// Channel  Handshake          Payload
// input    in_valid/in_ready  operation, process_id, alloc_pages, virtual_address, store_data
// output   out_valid/out_ready status, physical_address, load_data
//
// A load's result follows the dependent reads of the single-port page memory (pointer,
// table entry, byte), and a store's the first two reads and then its byte write; the next
// item is taken only after the result has been passed to the output register.
// A new process scans the used-page map page by page, a read and a check per page, and
// writes the table pointer or one table entry for each free page that it claims; a kill
// walks every entry of the process's table, freeing each page named, then the table page.
// After reset all PAGE_TOTAL * 256 bytes are cleared, one byte a cycle, with page 0 marked
// used in the map, before in_ready rises.
// The output register lets the next item be accepted while a result waits for out_ready.
module paged_memory_manager_top #(
	parameter int PAGE_TOTAL = pmm_pkg::PMM_PAGE_TOTAL
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] operation,
	input logic [7:0] process_id,
	input logic [6:0] alloc_pages,
	input logic [13:0] virtual_address,
	input logic [7:0] store_data,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] status,
	output logic [15:0] physical_address,
	output logic [7:0] load_data
);
	import pmm_pkg::*;

	localparam int ADDR_W = $clog2(PAGE_TOTAL) + PMM_OFS_W;

	logic mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic [7:0] mem_wdata, mem_rdata;
	logic res_valid, res_ready;
	res_t res, res_q;
	logic out_valid_q;

	pmm_ctrl #(.PAGE_TOTAL(PAGE_TOTAL)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.process_id(process_id),
		.alloc_pages(alloc_pages),
		.virtual_address(virtual_address),
		.store_data(store_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.mem_we(mem_we),
		.mem_addr(mem_addr),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata)
	);

	pmm_mem #(.PAGE_TOTAL(PAGE_TOTAL)) u_mem (
		.clk(clk),
		.we(mem_we),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = res_q.status;
	assign physical_address = res_q.physical_address;
	assign load_data = res_q.load_data;

endmodule

[src/pmm_mem.sv]
module pmm_mem #(
	parameter int PAGE_TOTAL = pmm_pkg::PMM_PAGE_TOTAL
) (
	input logic clk,
	input logic we,
	input logic [$clog2(PAGE_TOTAL) + pmm_pkg::PMM_OFS_W - 1:0] addr,
	input logic [7:0] wdata,
	output logic [7:0] rdata
);
	import pmm_pkg::*;

	localparam int DEPTH = PAGE_TOTAL * PMM_PAGE_BYTES;

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// Single port, read data registered; a write returns the old byte.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

[src/pmm_ctrl.sv]
module pmm_ctrl #(
	parameter int PAGE_TOTAL = pmm_pkg::PMM_PAGE_TOTAL
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] operation,
	input logic [7:0] process_id,
	input logic [6:0] alloc_pages,
	input logic [13:0] virtual_address,
	input logic [7:0] store_data,
	output logic res_valid,
	input logic res_ready,
	output pmm_pkg::res_t res,
	output logic mem_we,
	output logic [$clog2(PAGE_TOTAL) + pmm_pkg::PMM_OFS_W - 1:0] mem_addr,
	output logic [7:0] mem_wdata,
	input logic [7:0] mem_rdata
);
	import pmm_pkg::*;

	localparam int PG_W = $clog2(PAGE_TOTAL);
	localparam int ADDR_W = PG_W + PMM_OFS_W;
	localparam int DEPTH = PAGE_TOTAL * PMM_PAGE_BYTES;
	localparam int KI_W = $clog2(PAGE_TOTAL);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_SCAN_RD = 4'd2;
	localparam logic [3:0] S_SCAN_CHK = 4'd3;
	localparam logic [3:0] S_WR_PTR = 4'd4;
	localparam logic [3:0] S_WR_ENT = 4'd5;
	localparam logic [3:0] S_PTR_RD = 4'd6;
	localparam logic [3:0] S_PTR_GOT = 4'd7;
	localparam logic [3:0] S_K_RD = 4'd8;
	localparam logic [3:0] S_K_CHK = 4'd9;
	localparam logic [3:0] S_K_TBL = 4'd10;
	localparam logic [3:0] S_ENT_GOT = 4'd11;
	localparam logic [3:0] S_LD_GOT = 4'd12;
	localparam logic [3:0] S_DONE = 4'd13;

	logic [3:0] state_q, state_d;
	logic [ADDR_W-1:0] clr_q, clr_d;

	logic [1:0] op_q;
	logic [7:0] pid_q;
	logic [6:0] count_q;
	logic [13:0] va_q;
	logic [7:0] data_q;
	logic [PG_W-1:0] cursor_q;
	logic want_tbl_q;
	logic [7:0] table_q;
	logic [7:0] page_q;
	logic [6:0] v_q;
	logic [KI_W-1:0] ki_q;
	logic [1:0] status_q;
	logic [15:0] paddr_q;
	logic [7:0] ldata_q;

	logic rd_free, rd_in_range, cur_last, ki_last, alloc_done;
	logic [6:0] v_next;
	logic [ADDR_W-1:0] pid_slot_addr, ent_addr, kill_addr, xlat_addr, acc_addr;

	assign rd_free = (mem_rdata == MAP_FREE);
	assign rd_in_range = (mem_rdata < 8'(PAGE_TOTAL));
	assign cur_last = (cursor_q == PG_W'(PAGE_TOTAL - 1));
	assign ki_last = (ki_q == KI_W'(PAGE_TOTAL - 1));
	assign v_next = (state_q == S_WR_PTR) ? 7'd0 : v_q + 7'd1;
	assign alloc_done = (v_next == count_q);

	assign pid_slot_addr = ADDR_W'(9'(PMM_PTR_BASE) + {1'b0, pid_q});
	assign ent_addr = {table_q[PG_W-1:0], 8'(v_q)};
	assign kill_addr = {table_q[PG_W-1:0], 8'(ki_q)};
	assign xlat_addr = {mem_rdata[PG_W-1:0], 8'(va_q[13:PMM_OFS_W])};
	assign acc_addr = {mem_rdata[PG_W-1:0], va_q[PMM_OFS_W-1:0]};

	always_comb begin
		mem_we = 1'b0;
		mem_addr = '0;
		mem_wdata = MAP_FREE;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_addr = clr_q;
				mem_wdata = (clr_q == '0) ? MAP_USED : MAP_FREE;
			end
			S_SCAN_RD: begin
				mem_addr = ADDR_W'(cursor_q);
			end
			S_SCAN_CHK: begin
				mem_we = rd_free;
				mem_addr = ADDR_W'(cursor_q);
				mem_wdata = MAP_USED;
			end
			S_WR_PTR: begin
				mem_we = 1'b1;
				mem_addr = pid_slot_addr;
				mem_wdata = table_q;
			end
			S_WR_ENT: begin
				mem_we = 1'b1;
				mem_addr = ent_addr;
				mem_wdata = page_q;
			end
			S_PTR_RD: begin
				mem_addr = pid_slot_addr;
			end
			S_PTR_GOT: begin
				mem_addr = xlat_addr;
			end
			S_K_RD: begin
				mem_addr = kill_addr;
			end
			S_K_CHK: begin
				mem_we = !rd_free;
				mem_addr = ADDR_W'(mem_rdata);
			end
			S_K_TBL: begin
				mem_we = 1'b1;
				mem_addr = ADDR_W'(table_q);
			end
			S_ENT_GOT: begin
				mem_we = rd_in_range && (op_q == OP_STORE);
				mem_addr = acc_addr;
				mem_wdata = data_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		clr_d = clr_q;
		unique case (state_q)
			S_CLEAR: begin
				clr_d = clr_q + 1'b1;
				if (clr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = (operation == OP_NEW) ? S_SCAN_RD : S_PTR_RD;
				end
			end
			S_SCAN_RD: state_d = S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (rd_free) begin
					state_d = want_tbl_q ? S_WR_PTR : S_WR_ENT;
				end else if (cur_last) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_WR_PTR, S_WR_ENT: begin
				state_d = (alloc_done || cur_last) ? S_DONE : S_SCAN_RD;
			end
			S_PTR_RD: state_d = S_PTR_GOT;
			S_PTR_GOT: begin
				if (op_q == OP_KILL) begin
					state_d = rd_in_range ? S_K_RD : S_K_TBL;
				end else begin
					state_d = rd_in_range ? S_ENT_GOT : S_DONE;
				end
			end
			S_K_RD: state_d = S_K_CHK;
			S_K_CHK: state_d = ki_last ? S_K_TBL : S_K_RD;
			S_K_TBL: state_d = S_DONE;
			S_ENT_GOT: begin
				state_d = (rd_in_range && op_q == OP_LOAD) ? S_LD_GOT : S_DONE;
			end
			S_LD_GOT: state_d = S_DONE;
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
		end else begin
			state_q <= state_d;
			clr_q <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q <= operation;
				pid_q <= process_id;
				count_q <= alloc_pages;
				va_q <= virtual_address;
				data_q <= store_data;
				cursor_q <= '0;
				want_tbl_q <= 1'b1;
				status_q <= ST_OK;
				paddr_q <= '0;
				ldata_q <= '0;
			end
			S_SCAN_CHK: begin
				if (rd_free) begin
					if (want_tbl_q) begin
						table_q <= 8'(cursor_q);
					end else begin
						page_q <= 8'(cursor_q);
					end
				end else if (cur_last) begin
					status_q <= want_tbl_q ? ST_NO_TABLE : ST_NO_DATA;
				end else begin
					cursor_q <= cursor_q + 1'b1;
				end
			end
			S_WR_PTR, S_WR_ENT: begin
				// Pages only become used during one allocation, so the search
				// resumes just past the page found last.
				want_tbl_q <= 1'b0;
				v_q <= v_next;
				if (!alloc_done) begin
					if (cur_last) begin
						status_q <= ST_NO_DATA;
					end else begin
						cursor_q <= cursor_q + 1'b1;
					end
				end
			end
			S_PTR_GOT: begin
				table_q <= mem_rdata;
				ki_q <= '0;
				if (op_q != OP_KILL && !rd_in_range) begin
					status_q <= ST_RANGE;
				end
			end
			S_K_CHK: begin
				ki_q <= ki_q + 1'b1;
			end
			S_ENT_GOT: begin
				paddr_q <= {mem_rdata, va_q[PMM_OFS_W-1:0]};
				if (!rd_in_range) begin
					status_q <= ST_RANGE;
				end
			end
			S_LD_GOT: begin
				ldata_q <= mem_rdata;
			end
			default: begin
			end
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res.status = status_q;
	assign res.physical_address = paddr_q;
	assign res.load_data = ldata_q;

endmodule

[src/pmm_chk.sv]
module pmm_chk #(
	parameter int PAGE_TOTAL = pmm_pkg::PMM_PAGE_TOTAL
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] status,
	input logic [15:0] physical_address,
	input logic [7:0] load_data
);
	import pmm_pkg::*;

	// The block works on one item at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an item was accepted");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(physical_address) && $stable(load_data))
		else $error("result dropped or changed while stalled");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> load_data == 8'd0)
		else $error("load data on a failed item");

	a_alloc_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NO_TABLE || status == ST_NO_DATA)
			|-> physical_address == 16'd0)
		else $error("address reported on an allocation failure");

	// A range error carries either no address or one beyond the last page.
	a_range_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_RANGE
			|-> physical_address == 16'd0 || physical_address[15:8] >= 8'(PAGE_TOTAL))
		else $error("range error on an address inside the memory");

endmodule

bind paged_memory_manager_top pmm_chk #(.PAGE_TOTAL(PAGE_TOTAL)) u_pmm_chk (.*);
